[src/pgp_pkg.sv]
// ----------------------------------------------------------------------------
// pgp_pkg: shared types and constants of the planar geometric predicates
// Holds the request and response payloads, the stage-to-stage bundle,
// the request codes and the verdict codes.
// ----------------------------------------------------------------------------
package pgp_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned DiffW     = CoordBits + 1;      // coordinate difference
  localparam int unsigned ProdW     = 2 * DiffW;          // product of two differences
  localparam int unsigned SumW      = ProdW + 1;          // sum of two such products
  localparam int unsigned BigW      = 2 * SumW;           // product of two sums
  localparam int unsigned DetW      = BigW + 2;           // sum of up to three big products
  localparam int unsigned TolW      = 16;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned NumPairs  = 12;
  localparam int unsigned NumSums   = NumPairs / 2;
  localparam int unsigned NumBig    = 6;

  typedef enum logic [2:0] {
    ReqOrient     = 3'd0,
    ReqCircle     = 3'd1,
    ReqTriangle   = 3'd2,
    ReqDiamCircle = 3'd3,
    ReqDiamLens   = 3'd4
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOrientTol = 8'd0,
    CfgCircleTol = 8'd1
  } cfg_index_e;

  // Verdict codes
  localparam logic [1:0] VerdictCcw = 2'd0;
  localparam logic [1:0] VerdictCw  = 2'd1;
  localparam logic [1:0] VerdictLin = 2'd2;
  localparam logic [1:0] VerdictIn  = 2'd0;
  localparam logic [1:0] VerdictOn  = 2'd1;
  localparam logic [1:0] VerdictOut = 2'd2;
  localparam logic [1:0] VerdictNo  = 2'd0;
  localparam logic [1:0] VerdictYes = 2'd1;

  typedef struct packed {
    logic [2:0]                  req_type;
    logic signed [CoordBits-1:0] point_a_x;
    logic signed [CoordBits-1:0] point_a_y;
    logic signed [CoordBits-1:0] point_b_x;
    logic signed [CoordBits-1:0] point_b_y;
    logic signed [CoordBits-1:0] point_c_x;
    logic signed [CoordBits-1:0] point_c_y;
    logic signed [CoordBits-1:0] point_d_x;
    logic signed [CoordBits-1:0] point_d_y;
  } pgp_req_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       degenerate;
  } pgp_rsp_t;

  // Bundle from the front half to the back half
  typedef struct packed {
    logic [2:0]                    req_type;
    logic [NumSums-1:0][SumW-1:0]  sum;
  } pgp_mid_t;

  function automatic logic signed [DiffW-1:0] coord_sub(
      input logic signed [CoordBits-1:0] a,
      input logic signed [CoordBits-1:0] b);
    return $signed({a[CoordBits-1], a}) - $signed({b[CoordBits-1], b});
  endfunction

  // pos when v > tol, neg when v < -tol, mid otherwise
  function automatic logic [1:0] three_way(
      input logic signed [DetW-1:0] v,
      input logic [TolW-1:0]        tol,
      input logic [1:0]             pos,
      input logic [1:0]             neg,
      input logic [1:0]             mid);
    logic signed [DetW-1:0] t;
    logic [1:0]             r;
    t = $signed({{(DetW-TolW){1'b0}}, tol});
    if (v > t) begin
      r = pos;
    end else if (v < -t) begin
      r = neg;
    end else begin
      r = mid;
    end
    return r;
  endfunction

endpackage

[src/pgp_front.sv]
// ----------------------------------------------------------------------------
// pgp_front: difference, product and pair-sum stages
// Stage 1 picks twelve operand pairs of coordinate differences per request,
// stage 2 multiplies them, stage 3 adds them in pairs.
// ----------------------------------------------------------------------------
module pgp_front import pgp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  pgp_req_t req_i,
  output logic     valid_o,
  output pgp_mid_t mid_o
);

  logic signed [DiffW-1:0] op_a_d [NumPairs];
  logic signed [DiffW-1:0] op_b_d [NumPairs];
  logic signed [DiffW-1:0] op_a_q [NumPairs];
  logic signed [DiffW-1:0] op_b_q [NumPairs];
  logic signed [ProdW-1:0] prod_q [NumPairs];
  logic [NumSums-1:0][SumW-1:0] sum_q;
  logic [2:0] type1_q, type2_q, type3_q;
  logic       v1_q, v2_q, v3_q;

  logic signed [DiffW-1:0] adx, ady, bdx, bdy, cdx, cdy;
  logic signed [DiffW-1:0] e0x, e0y, e1x, e1y, e2x, e2y;
  logic signed [DiffW-1:0] px, py, qx, qy;

  always_comb begin
    adx = coord_sub(req_i.point_a_x, req_i.point_d_x);
    ady = coord_sub(req_i.point_a_y, req_i.point_d_y);
    bdx = coord_sub(req_i.point_b_x, req_i.point_d_x);
    bdy = coord_sub(req_i.point_b_y, req_i.point_d_y);
    cdx = coord_sub(req_i.point_c_x, req_i.point_d_x);
    cdy = coord_sub(req_i.point_c_y, req_i.point_d_y);
    e0x = coord_sub(req_i.point_c_x, req_i.point_a_x);
    e0y = coord_sub(req_i.point_c_y, req_i.point_a_y);
    e1x = coord_sub(req_i.point_b_x, req_i.point_a_x);
    e1y = coord_sub(req_i.point_b_y, req_i.point_a_y);
    e2x = coord_sub(req_i.point_d_x, req_i.point_a_x);
    e2y = coord_sub(req_i.point_d_y, req_i.point_a_y);
    px  = coord_sub(req_i.point_a_x, req_i.point_c_x);
    py  = coord_sub(req_i.point_a_y, req_i.point_c_y);
    qx  = coord_sub(req_i.point_b_x, req_i.point_c_x);
    qy  = coord_sub(req_i.point_b_y, req_i.point_c_y);
    for (int k = 0; k < NumPairs; k++) begin
      op_a_d[k] = '0;
      op_b_d[k] = '0;
    end
    case (req_i.req_type)
      ReqOrient: begin
        // det = e1x*e0y - e1y*e0x
        op_a_d[0] = e1x;  op_b_d[0] = e0y;
        op_a_d[1] = -e1y; op_b_d[1] = e0x;
      end
      ReqCircle: begin
        op_a_d[0]  = adx;  op_b_d[0]  = adx;
        op_a_d[1]  = ady;  op_b_d[1]  = ady;
        op_a_d[2]  = bdx;  op_b_d[2]  = bdx;
        op_a_d[3]  = bdy;  op_b_d[3]  = bdy;
        op_a_d[4]  = cdx;  op_b_d[4]  = cdx;
        op_a_d[5]  = cdy;  op_b_d[5]  = cdy;
        op_a_d[6]  = bdx;  op_b_d[6]  = cdy;
        op_a_d[7]  = -cdx; op_b_d[7]  = bdy;
        op_a_d[8]  = cdx;  op_b_d[8]  = ady;
        op_a_d[9]  = -adx; op_b_d[9]  = cdy;
        op_a_d[10] = adx;  op_b_d[10] = bdy;
        op_a_d[11] = -bdx; op_b_d[11] = ady;
      end
      ReqTriangle: begin
        op_a_d[0] = e0x; op_b_d[0] = e0x;
        op_a_d[1] = e0y; op_b_d[1] = e0y;
        op_a_d[2] = e0x; op_b_d[2] = e1x;
        op_a_d[3] = e0y; op_b_d[3] = e1y;
        op_a_d[4] = e0x; op_b_d[4] = e2x;
        op_a_d[5] = e0y; op_b_d[5] = e2y;
        op_a_d[6] = e1x; op_b_d[6] = e1x;
        op_a_d[7] = e1y; op_b_d[7] = e1y;
        op_a_d[8] = e1x; op_b_d[8] = e2x;
        op_a_d[9] = e1y; op_b_d[9] = e2y;
      end
      ReqDiamCircle, ReqDiamLens: begin
        op_a_d[0] = px; op_b_d[0] = qx;
        op_a_d[1] = py; op_b_d[1] = qy;
        op_a_d[2] = px; op_b_d[2] = px;
        op_a_d[3] = py; op_b_d[3] = py;
        op_a_d[4] = qx; op_b_d[4] = qx;
        op_a_d[5] = qy; op_b_d[5] = qy;
      end
      default: begin
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      type1_q <= req_i.req_type;
      type2_q <= type1_q;
      type3_q <= type2_q;
      for (int k = 0; k < NumPairs; k++) begin
        op_a_q[k] <= op_a_d[k];
        op_b_q[k] <= op_b_d[k];
        prod_q[k] <= op_a_q[k] * op_b_q[k];
      end
      for (int j = 0; j < NumSums; j++) begin
        sum_q[j] <= $signed({prod_q[2*j][ProdW-1], prod_q[2*j]})
                  + $signed({prod_q[2*j+1][ProdW-1], prod_q[2*j+1]});
      end
    end
  end

  assign valid_o        = v3_q;
  assign mid_o.req_type = type3_q;
  assign mid_o.sum      = sum_q;

endmodule

[src/pgp_back.sv]
// ----------------------------------------------------------------------------
// pgp_back: wide product, combine and decision stages
// Stage 4 forms six wide products, stage 5 combines them into determinant,
// denominator and numerators, stage 6 holds the verdict for the consumer.
// ----------------------------------------------------------------------------
module pgp_back import pgp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  pgp_mid_t        mid_i,
  input  logic [TolW-1:0] orient_tol_i,
  input  logic [TolW-1:0] circle_tol_i,
  output logic            valid_o,
  output pgp_rsp_t        rsp_o
);

  logic signed [SumW-1:0] s [NumSums];
  logic signed [SumW-1:0] x_d [NumBig];
  logic signed [SumW-1:0] y_d [NumBig];
  logic signed [BigW-1:0] big_q [NumBig];
  logic signed [DetW-1:0] det_q, un_q, vn_q;
  logic signed [DetW+1:0] bary_sum;
  logic signed [DetW-1:0] s0_ext;
  logic [1:0] ovd4_q, ovd5_q;
  logic       dle4_q, dle5_q;
  logic [2:0] type4_q, type5_q;
  logic       v4_q, v5_q, v6_q;
  logic signed [DetW-1:0] det_d, un_d, vn_d;
  pgp_rsp_t   rsp_d, rsp_q;

  always_comb begin
    for (int j = 0; j < NumSums; j++) begin
      s[j] = $signed(mid_i.sum[j]);
    end
    s0_ext = $signed({{(DetW-SumW){s[0][SumW-1]}}, s[0]});
    for (int k = 0; k < NumBig; k++) begin
      x_d[k] = '0;
      y_d[k] = '0;
    end
    case (mid_i.req_type)
      ReqCircle: begin
        x_d[0] = s[0]; y_d[0] = s[3];
        x_d[1] = s[1]; y_d[1] = s[4];
        x_d[2] = s[2]; y_d[2] = s[5];
      end
      ReqTriangle: begin
        x_d[0] = s[0]; y_d[0] = s[3];   // d00*d11
        x_d[1] = s[1]; y_d[1] = s[1];   // d01*d01
        x_d[2] = s[3]; y_d[2] = s[2];   // d11*d02
        x_d[3] = s[1]; y_d[3] = s[4];   // d01*d12
        x_d[4] = s[0]; y_d[4] = s[4];   // d00*d12
        x_d[5] = s[1]; y_d[5] = s[2];   // d01*d02
      end
      ReqDiamLens: begin
        x_d[0] = s[0]; y_d[0] = s[0];
        x_d[1] = s[1]; y_d[1] = s[2];
      end
      default: begin
      end
    endcase
  end

  // Combine wide products
  always_comb begin
    det_d = '0;
    un_d  = '0;
    vn_d  = '0;
    case (type4_q)
      ReqCircle: begin
        det_d = DetW'(big_q[0]) + DetW'(big_q[1]) + DetW'(big_q[2]);
      end
      ReqTriangle: begin
        det_d = DetW'(big_q[0]) - DetW'(big_q[1]);
        un_d  = DetW'(big_q[2]) - DetW'(big_q[3]);
        vn_d  = DetW'(big_q[4]) - DetW'(big_q[5]);
      end
      ReqDiamLens: begin
        det_d = (DetW'(big_q[0]) <<< 2) - DetW'(big_q[1]);
      end
      default: begin
      end
    endcase
  end

  // Decide
  always_comb begin
    bary_sum = (DetW+2)'(un_q) + (DetW+2)'(vn_q) - (DetW+2)'(det_q);
    rsp_d    = '0;
    case (type5_q)
      ReqOrient: begin
        rsp_d.verdict = ovd5_q;
      end
      ReqCircle: begin
        rsp_d.verdict = three_way(det_q, circle_tol_i, VerdictIn, VerdictOut, VerdictOn);
      end
      ReqTriangle: begin
        if (det_q == '0) begin
          rsp_d.degenerate = 1'b1;
          rsp_d.verdict    = VerdictOut;
        end else if (un_q >= 0 && vn_q >= 0) begin
          if (bary_sum < 0) begin
            rsp_d.verdict = VerdictIn;
          end else if (bary_sum == '0) begin
            rsp_d.verdict = VerdictOn;
          end else begin
            rsp_d.verdict = VerdictOut;
          end
        end else begin
          rsp_d.verdict = VerdictOut;
        end
      end
      ReqDiamCircle: begin
        rsp_d.verdict = dle5_q ? VerdictYes : VerdictNo;
      end
      ReqDiamLens: begin
        rsp_d.verdict = (dle5_q && det_q >= 0) ? VerdictYes : VerdictNo;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NumBig; k++) begin
        big_q[k] <= x_d[k] * y_d[k];
      end
      ovd4_q  <= three_way(s0_ext, orient_tol_i, VerdictCcw, VerdictCw, VerdictLin);
      dle4_q  <= (s[0] <= 0);
      type4_q <= mid_i.req_type;
      det_q   <= det_d;
      un_q    <= un_d;
      vn_q    <= vn_d;
      ovd5_q  <= ovd4_q;
      dle5_q  <= dle4_q;
      type5_q <= type4_q;
      rsp_q   <= rsp_d;
    end
  end

  assign valid_o = v6_q;
  assign rsp_o   = rsp_q;

endmodule

[src/planar_geometric_predicates.sv]
// ----------------------------------------------------------------------------
// planar_geometric_predicates: pipelined exact planar predicates
// Orientation, in-circle, in-triangle, diametral circle and diametral lens
// tests on integer points, answered by exact wide integer arithmetic.
//
//   channel   direction  handshake                  payload
//   in        to block   in_valid_i / in_ready_o    in_req_i  (pgp_req_t)
//   out       from block out_valid_o / out_ready_i  out_rsp_o (pgp_rsp_t)
//   cfg       to block   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle while the output is not stalled; six register stages
// (differences, small products, pair sums, wide products, combine,
// decision/output register) lie between a request and its response.
// Reset clears the valid bits and both tolerances to zero.
// A stall on the output freezes the whole pipeline at once: no request is
// lost or repeated, and in_ready_o is low only while the output holds a
// response that is not taken.
// ----------------------------------------------------------------------------
module planar_geometric_predicates import pgp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pgp_req_t           in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pgp_rsp_t           out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TolW-1:0]    cfg_data_i
);

  logic            en;
  logic            mid_valid;
  pgp_mid_t        mid;
  logic [TolW-1:0] orient_tol_q, circle_tol_q;

  // Advance every stage unless the output holds an untaken response
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // Tolerance registers; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_tol_q <= '0;
      circle_tol_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOrientTol: orient_tol_q <= cfg_data_i;
        CfgCircleTol: circle_tol_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  pgp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (mid_valid),
    .mid_o   (mid)
  );

  pgp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (mid_valid),
    .mid_i        (mid),
    .orient_tol_i (orient_tol_q),
    .circle_tol_i (circle_tol_q),
    .valid_o      (out_valid_o),
    .rsp_o        (out_rsp_o)
  );

  // A degenerate triangle always reports outside
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.degenerate |-> out_rsp_o.verdict == VerdictOut)
    else $error("degenerate response without outside verdict");

  // The verdict code three is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.verdict != 2'd3)
    else $error("verdict code out of range");

  // An orientation tolerance write lands in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == CfgOrientTol |=> orient_tol_q == $past(cfg_data_i))
    else $error("orientation tolerance write lost");

  // Hold an untaken response unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

endmodule

[verif/tb_planar_geometric_predicates.sv]
// ----------------------------------------------------------------------------
// tb_planar_geometric_predicates: self-checking bench for the predicate block
// Drives directed and random requests through all five predicates under
// several tolerance settings, predicts each verdict with exact wide integer
// arithmetic and compares every response in order against the prediction.
// ----------------------------------------------------------------------------
module tb_planar_geometric_predicates;
  import pgp_pkg::*;

  localparam int Latency = 6;

  typedef logic signed [127:0] wide_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  pgp_req_t           in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  pgp_rsp_t           out_rsp_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [TolW-1:0]    cfg_data_i;

  // Local copy of the tolerance registers
  logic [TolW-1:0] orient_tol_q;
  logic [TolW-1:0] circle_tol_q;

  pgp_rsp_t verdict_q[$];
  int       mismatch_cnt;
  bit       quiet_mode;     // no random idling on either side
  bit       hold_rsp;       // receiver holds off for a long stretch

  planar_geometric_predicates u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Three-way split of a determinant against a tolerance
  function automatic logic [1:0] split_det(wide_t det, logic [TolW-1:0] tol,
                                           logic [1:0] pos, logic [1:0] neg,
                                           logic [1:0] mid);
    wide_t t;
    t = wide_t'({1'b0, tol});
    if (det > t) return pos;
    if (det < -t) return neg;
    return mid;
  endfunction

  // Exact verdict for one request
  function automatic pgp_rsp_t predict_verdict(pgp_req_t r);
    pgp_rsp_t o;
    wide_t ax, ay, bx, by, cx, cy, dx, dy;
    wide_t adx, ady, bdx, bdy, cdx, cdy, al, bl, cl, det;
    wide_t d00, d01, d02, d11, d12, den, un, vn, s;
    wide_t px, py, qx, qy, dot, np, nq;
    ax = wide_t'(r.point_a_x); ay = wide_t'(r.point_a_y);
    bx = wide_t'(r.point_b_x); by = wide_t'(r.point_b_y);
    cx = wide_t'(r.point_c_x); cy = wide_t'(r.point_c_y);
    dx = wide_t'(r.point_d_x); dy = wide_t'(r.point_d_y);
    o = '0;
    case (r.req_type)
      ReqOrient: begin
        det = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        o.verdict = split_det(det, orient_tol_q, VerdictCcw, VerdictCw, VerdictLin);
      end
      ReqCircle: begin
        adx = ax - dx; ady = ay - dy;
        bdx = bx - dx; bdy = by - dy;
        cdx = cx - dx; cdy = cy - dy;
        al = adx * adx + ady * ady;
        bl = bdx * bdx + bdy * bdy;
        cl = cdx * cdx + cdy * cdy;
        det = al * (bdx * cdy - cdx * bdy) + bl * (cdx * ady - adx * cdy)
            + cl * (adx * bdy - bdx * ady);
        o.verdict = split_det(det, circle_tol_q, VerdictIn, VerdictOut, VerdictOn);
      end
      ReqTriangle: begin
        d00 = (cx - ax) * (cx - ax) + (cy - ay) * (cy - ay);
        d01 = (cx - ax) * (bx - ax) + (cy - ay) * (by - ay);
        d02 = (cx - ax) * (dx - ax) + (cy - ay) * (dy - ay);
        d11 = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
        d12 = (bx - ax) * (dx - ax) + (by - ay) * (dy - ay);
        den = d00 * d11 - d01 * d01;
        un  = d11 * d02 - d01 * d12;
        vn  = d00 * d12 - d01 * d02;
        if (den == 0) begin
          o.degenerate = 1'b1;
          o.verdict    = VerdictOut;
        end else if (un >= 0 && vn >= 0) begin
          s = un + vn - den;
          o.verdict = (s < 0) ? VerdictIn : ((s == 0) ? VerdictOn : VerdictOut);
        end else begin
          o.verdict = VerdictOut;
        end
      end
      ReqDiamCircle, ReqDiamLens: begin
        px = ax - cx; py = ay - cy;
        qx = bx - cx; qy = by - cy;
        dot = px * qx + py * qy;
        np  = px * px + py * py;
        nq  = qx * qx + qy * qy;
        if (dot > 0) o.verdict = VerdictNo;
        else if (r.req_type == ReqDiamCircle) o.verdict = VerdictYes;
        else o.verdict = (4 * dot * dot >= np * nq) ? VerdictYes : VerdictNo;
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR %0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  function automatic bit idle_roll();
    return !quiet_mode && ($urandom_range(99) < 9);
  endfunction

  // Send one request, with random idle cycles ahead of it; valid stays high
  // after acceptance until the next idle cycle or the caller drops it
  task automatic send_request(pgp_req_t r);
    while (idle_roll()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    verdict_q.push_back(predict_verdict(r));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write one tolerance register; the pipeline must be drained first
  task automatic write_tol(cfg_index_e idx, logic [TolW-1:0] val);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 2) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgOrientTol) orient_tol_q = val;
    else circle_tol_q = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: drop ready at random or during a hold-off
  always @(negedge clk_i) begin
    out_ready_i <= !hold_rsp && !idle_roll();
  end

  // Compare each accepted response with the oldest prediction
  always @(posedge clk_i) begin
    pgp_rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("response with no request pending");
      end else begin
        exp_rsp = verdict_q.pop_front();
        if (out_rsp_o.verdict !== exp_rsp.verdict)
          report_mismatch($sformatf("verdict %0d, expected %0d",
                                    out_rsp_o.verdict, exp_rsp.verdict));
        if (out_rsp_o.degenerate !== exp_rsp.degenerate)
          report_mismatch($sformatf("degenerate %0b, expected %0b",
                                    out_rsp_o.degenerate, exp_rsp.degenerate));
      end
    end
  end

  function automatic pgp_req_t make_req(logic [2:0] op, int ax, int ay, int bx,
                                        int by, int cx, int cy, int dx, int dy);
    pgp_req_t r;
    r.req_type  = op;
    r.point_a_x = 16'(ax); r.point_a_y = 16'(ay);
    r.point_b_x = 16'(bx); r.point_b_y = 16'(by);
    r.point_c_x = 16'(cx); r.point_c_y = 16'(cy);
    r.point_d_x = 16'(dx); r.point_d_y = 16'(dy);
    return r;
  endfunction

  function automatic int rand_coord(int span);
    int v;
    case ($urandom_range(3))
      0:       v = $urandom_range(65535);   // full range
      1:       v = $urandom_range(2 * span) - span;
      2:       v = $urandom_range(1) ? 32767 : -32768;
      default: v = $urandom_range(16) - 8;  // tiny, hits ties and collinear
    endcase
    return v;
  endfunction

  function automatic pgp_req_t rand_req();
    pgp_req_t r;
    int span;
    span = $urandom_range(1) ? 64 : 4000;
    r = make_req(3'($urandom_range(99) < 3 ? $urandom_range(7, 5) : $urandom_range(4)),
                 rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
                 rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
    // Reuse points now and then so ties and degenerate cases come up
    if ($urandom_range(7) == 0) begin
      r.point_c_x = r.point_a_x;
      r.point_c_y = r.point_a_y;
    end
    if ($urandom_range(7) == 0) begin
      r.point_d_x = r.point_b_x;
      r.point_d_y = r.point_b_y;
    end
    return r;
  endfunction

  // Extremes, every predicate, degenerate and unused selectors
  task automatic test_directed();
    send_request(make_req(ReqOrient, 0, 0, 10, 0, 0, 10, 0, 0));        // ccw
    send_request(make_req(ReqOrient, 0, 0, 0, 10, 10, 0, 0, 0));        // cw
    send_request(make_req(ReqOrient, 0, 0, 5, 5, 10, 10, 0, 0));        // collinear
    send_request(make_req(ReqOrient, -32768, -32768, 32767, -32768,
                          32767, 32767, 0, 0));
    send_request(make_req(ReqOrient, 32767, 32767, -32768, 32767,
                          32767, -32768, 0, 0));
    send_request(make_req(ReqCircle, 10, 0, 0, 10, -10, 0, 0, 0));      // in
    send_request(make_req(ReqCircle, 10, 0, 0, 10, -10, 0, 0, -10));    // on
    send_request(make_req(ReqCircle, 10, 0, 0, 10, -10, 0, 50, 50));    // out
    send_request(make_req(ReqCircle, -32768, -32768, 32767, -32768,
                          32767, 32767, -32768, 32767));
    send_request(make_req(ReqCircle, 32767, -32768, -32768, 32767,
                          -32768, -32768, 32767, 32767));
    send_request(make_req(ReqTriangle, 0, 0, 10, 0, 0, 10, 2, 2));      // in
    send_request(make_req(ReqTriangle, 0, 0, 10, 0, 0, 10, 5, 5));      // on edge
    send_request(make_req(ReqTriangle, 0, 0, 10, 0, 0, 10, 9, 9));      // out
    send_request(make_req(ReqTriangle, 0, 0, 10, 0, 0, 10, -1, 2));     // negative v
    send_request(make_req(ReqTriangle, 0, 0, 5, 5, 10, 10, 2, 2));      // zero area
    send_request(make_req(ReqTriangle, -32768, -32768, 32767, -32768,
                          -32768, 32767, 0, 0));
    send_request(make_req(ReqDiamCircle, -10, 0, 10, 0, 0, 5, 0, 0));   // inside
    send_request(make_req(ReqDiamCircle, -10, 0, 10, 0, 0, 20, 0, 0));  // outside
    send_request(make_req(ReqDiamCircle, -10, 0, 10, 0, 0, 10, 0, 0));  // on circle
    send_request(make_req(ReqDiamLens, -10, 0, 10, 0, 0, 1, 0, 0));     // deep inside
    send_request(make_req(ReqDiamLens, -10, 0, 10, 0, 0, 8, 0, 0));     // outside lens
    send_request(make_req(ReqDiamLens, -10, 0, 10, 0, -10, 0, 0, 0));   // on end point
    send_request(make_req(ReqDiamLens, -32768, -32768, 32767, 32767,
                          0, 0, 0, 0));
    send_request(make_req(3'd5, 1, 2, 3, 4, 5, 6, 7, 8));
    send_request(make_req(3'd7, -32768, 32767, -32768, 32767, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    repeat (n) send_request(rand_req());
  endtask

  // Orientation and in-circle near their tolerance boundaries
  task automatic test_tolerance(int n);
    repeat (n) begin
      send_request(make_req($urandom_range(1) ? ReqOrient : ReqCircle,
                            $urandom_range(8) - 4, $urandom_range(8) - 4,
                            $urandom_range(300) - 150, $urandom_range(300) - 150,
                            $urandom_range(300) - 150, $urandom_range(300) - 150,
                            $urandom_range(8) - 4, $urandom_range(8) - 4));
    end
  endtask

  // Back-to-back stream with no idling at all
  task automatic test_streaming(int n);
    quiet_mode = 1'b1;
    test_random(n);
    quiet_mode = 1'b0;
  endtask

  // Hold the receiver off so the pipeline fills and stalls its input
  task automatic test_backpressure(int n);
    fork
      begin
        hold_rsp = 1'b1;
        repeat (60) @(negedge clk_i);
        hold_rsp = 1'b0;
      end
      test_random(n);
    join
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    out_ready_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgOrientTol;
    cfg_data_i   = '0;
    orient_tol_q = '0;
    circle_tol_q = '0;
    mismatch_cnt = 0;
    quiet_mode   = 1'b0;
    hold_rsp     = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(300);
    test_backpressure(40);
    write_tol(CfgOrientTol, 16'hFFFF);
    write_tol(CfgCircleTol, 16'hFFFF);
    test_tolerance(100);
    test_random(150);
    write_tol(CfgOrientTol, 16'd1);
    write_tol(CfgCircleTol, 16'd1000);
    test_tolerance(100);
    test_streaming(150);
    write_tol(CfgOrientTol, 16'($urandom_range(200)));
    write_tol(CfgCircleTol, 16'($urandom_range(65535)));
    test_tolerance(60);
    write_tol(CfgOrientTol, 16'd0);
    write_tol(CfgCircleTol, 16'd0);
    test_random(100);

    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (Latency * 4) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
